FILE: design/assert_macros.svh
// Shared assertion macros for the pose converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: design/eulq_pkg.sv
`default_nettype none
package eulq_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int TBL_LEN           = 30;
    // 720 degrees in Q16.16; one turn of the half angle.
    localparam longint MOD_RAW       = 47185920;
    // 46 turns lift any 32 bit angle to a positive value.
    localparam longint BIAS_RAW      = 46 * MOD_RAW;
    localparam longint CORDIC_X0     = 652032874;
    localparam longint Q30_ONE       = 1073741824;
    localparam int RED_STEPS         = 1;
    localparam int FRAC_STEPS        = 1;
    localparam int PROD_STEPS        = 32;
    localparam int IN_W              = 256;
    localparam int OUT_W             = 288;

    // Reciprocal of 45 for a small quotient: ceil(2^20 / 45).
    localparam logic [14:0] RECIP45  = 15'd23302;
    // Inverse of 45 modulo 2^32, used for exact division by 45.
    localparam logic [31:0] INV45    = 32'hA4FA4FA5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       red_step;
        logic       frac_step;
        logic       cord_init;
        logic       cord_step;
        logic [4:0] iter;
        logic       prod_step;
        logic       emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic changed;
        logic out_free;
    } stat_t;

    // CORDIC arc table, 2^32 per turn.
    function automatic logic [31:0] atan_phase(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Sine selects {third, first, second} for each product term.
    function automatic logic [2:0] term_sel(input logic [2:0] term);
        logic [2:0] v;
        case (term)
            3'd0: v = 3'b000;
            3'd1: v = 3'b111;
            3'd2: v = 3'b100;
            3'd3: v = 3'b011;
            3'd4: v = 3'b010;
            3'd5: v = 3'b101;
            3'd6: v = 3'b001;
            default: v = 3'b110;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/euler_degrees_to_quaternion_pose.sv
// Channel | Dir | Width | Contents
// s_*     | in  | 256   | stamp, translation, three angles
// m_*     | out | 288   | stamp, position, quaternion, change flag
//
// A changed pose passes through angle reduction by digit sums, an exact
// division multiply, the CORDIC at one step a cycle, and the product terms
// on the single shared 32x32 multiplier.
// An unchanged pose skips the angle work and waits in the emit state until the output register is free.
// Reset is asynchronous, active low, and restores the identity quaternion.
// A new transfer is taken while a result still waits in the output register.
`default_nettype none
module euler_degrees_to_quaternion_pose #(
    parameter int CORDIC_STAGES = eulq_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // stamp_seconds_in, stamp_nanoseconds_in, translation_x_in, translation_y_in,
    // translation_z_in, angle_first_deg, angle_second_deg, angle_third_deg, 2 pad bits
    input  wire logic [eulq_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // stamp_seconds_out, stamp_nanoseconds_out, position_x, position_y, position_z,
    // quat_w, quat_x, quat_y, quat_z, pose_changed, 1 pad bit
    output logic [eulq_pkg::OUT_W-1:0]       m_tdata
);
    import eulq_pkg::*;

    cmd_t  cmd;
    stat_t st;

    eulq_ctrl #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    eulq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

endmodule
`default_nettype wire

FILE: design/eulq_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module eulq_ctrl #(
    parameter int CORDIC_STAGES = eulq_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire eulq_pkg::stat_t st,
    output eulq_pkg::cmd_t     cmd
);
    import eulq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_FRAC = 3'd2;
    localparam logic [2:0] ST_CINI = 3'd3;
    localparam logic [2:0] ST_CORD = 3'd4;
    localparam logic [2:0] ST_PROD = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Sequencer: one phase per state, the counter walks each phase.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.iter      = cnt_reg[4:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = st.changed ? ST_RED : ST_EMIT;
                end
            end
            ST_RED:
            begin
                cmd.red_step = 1'b1;
                if (cnt_reg == 6'(RED_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FRAC;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_FRAC:
            begin
                cmd.frac_step = 1'b1;
                if (cnt_reg == 6'(FRAC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_CINI;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_CINI:
            begin
                cmd.cord_init = 1'b1;
                state_next    = ST_CORD;
            end
            ST_CORD:
            begin
                cmd.cord_step = 1'b1;
                if (cnt_reg == 6'(CORDIC_STAGES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_PROD;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_PROD:
            begin
                cmd.prod_step = 1'b1;
                if (cnt_reg == 6'(PROD_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, s_accept |=> (state_reg != ST_IDLE), "accepted transfer did not start work")
    `ASSERT_CLK(a_emit_free, clk, rst_n, cmd.emit |-> st.out_free, "result written over a pending transfer")
    `ASSERT_NEVER(a_frac_count, clk, rst_n, (state_reg == ST_FRAC) && (cnt_reg >= 6'(FRAC_STEPS)), "fraction step count overran")

endmodule
`default_nettype wire

FILE: design/eulq_dp.sv
`default_nettype none
module eulq_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [eulq_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [eulq_pkg::OUT_W-1:0]       m_tdata,
    input  wire eulq_pkg::cmd_t              cmd,
    output eulq_pkg::stat_t                  st
);
    import eulq_pkg::*;

    // Input fields.
    logic [31:0] in_sec, in_tx, in_ty, in_tz;
    logic [29:0] in_ns;
    logic [31:0] in_ang [3];

    assign in_sec    = s_tdata[31:0];
    assign in_ns     = s_tdata[61:32];
    assign in_tx     = s_tdata[93:62];
    assign in_ty     = s_tdata[125:94];
    assign in_tz     = s_tdata[157:126];
    assign in_ang[0] = s_tdata[189:158];
    assign in_ang[1] = s_tdata[221:190];
    assign in_ang[2] = s_tdata[253:222];

    logic [31:0] held_t_reg [3];
    logic [31:0] held_a_reg [3];
    logic [31:0] held_q_reg [4];
    logic [31:0] sec_reg, tx_reg, ty_reg, tz_reg;
    logic [29:0] ns_reg;
    logic        changed_reg;

    // Pose compare against the held values.
    assign st.changed = (in_tx != held_t_reg[0]) || (in_ty != held_t_reg[1]) ||
                        (in_tz != held_t_reg[2]) || (in_ang[0] != held_a_reg[0]) ||
                        (in_ang[1] != held_a_reg[1]) || (in_ang[2] != held_a_reg[2]);

    logic m_valid_reg;
    assign st.out_free = !m_valid_reg || m_tready;

    // Per-angle lanes: phase = round(angle * 2^16 / 720) as an exact
    // division by 45 of (angle * 4096 + 22), then CORDIC.
    logic [32:0] rem_reg  [3];
    logic [5:0]  res_reg  [3];
    logic [31:0] frac_reg [3];
    logic [1:0]  quad_reg [3];
    logic signed [33:0] cx_reg [3];
    logic signed [33:0] cy_reg [3];
    logic signed [32:0] cz_reg [3];
    logic signed [31:0] cos_v [3];
    logic signed [31:0] sin_v [3];

    localparam logic [33:0] BIAS34 = 34'(BIAS_RAW);

    logic [31:0] atan_v;
    assign atan_v  = atan_phase(cmd.iter);

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic [13:0] dsum;
        logic [28:0] qmul;
        logic [8:0]  q45;
        logic [13:0] q45x;
        logic [5:0]  res_v;
        logic [31:0] num, quo;
        logic [31:0] ph_raw, ph, sh;
        logic signed [33:0] dx, dy;

        // Since 4096 is one modulo 45, the 12 bit digit sum keeps the residue.
        assign dsum  = 14'(rem_reg[l][11:0]) + 14'(rem_reg[l][23:12]) +
                       14'(rem_reg[l][32:24]) + 14'd22;
        assign qmul  = 29'(dsum) * 29'(RECIP45);
        assign q45   = qmul[28:20];
        assign q45x  = 14'(q45) * 14'd45;
        assign res_v = 6'(dsum - q45x);

        // The numerator less its residue divides exactly, so its low word
        // times the inverse of 45 is the quotient modulo 2^32.
        assign num    = {rem_reg[l][19:0], 12'd22} - {26'd0, res_reg[l]};
        assign quo    = num * INV45;
        assign ph_raw = frac_reg[l];
        // The first two angles are negated.
        assign ph     = (l < 2) ? (32'd0 - ph_raw) : ph_raw;
        assign sh     = ph + 32'h2000_0000;
        assign dx     = cy_reg[l] >>> cmd.iter;
        assign dy     = cx_reg[l] >>> cmd.iter;

        // Quarter-turn correction of the rotated vector.
        always_comb
        begin
            case (quad_reg[l])
                2'd0:
                begin
                    cos_v[l] = 32'(cx_reg[l]);
                    sin_v[l] = 32'(cy_reg[l]);
                end
                2'd1:
                begin
                    cos_v[l] = 32'(-cy_reg[l]);
                    sin_v[l] = 32'(cx_reg[l]);
                end
                2'd2:
                begin
                    cos_v[l] = 32'(-cx_reg[l]);
                    sin_v[l] = 32'(-cy_reg[l]);
                end
                default:
                begin
                    cos_v[l] = 32'(cy_reg[l]);
                    sin_v[l] = 32'(-cx_reg[l]);
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                rem_reg[l] <= 33'({{2{in_ang[l][31]}}, in_ang[l]} + BIAS34);
            end
            else if (cmd.red_step)
            begin
                res_reg[l] <= res_v;
            end
            else if (cmd.frac_step)
            begin
                frac_reg[l] <= quo;
            end
            if (cmd.cord_init)
            begin
                quad_reg[l] <= sh[31:30];
                cx_reg[l]   <= 34'(CORDIC_X0);
                cy_reg[l]   <= '0;
                cz_reg[l]   <= $signed({3'b000, sh[29:0]}) - 33'sd536870912;
            end
            else if (cmd.cord_step)
            begin
                if (!cz_reg[l][32])
                begin
                    cx_reg[l] <= cx_reg[l] - dx;
                    cy_reg[l] <= cy_reg[l] + dy;
                    cz_reg[l] <= cz_reg[l] - $signed({1'b0, atan_v});
                end
                else
                begin
                    cx_reg[l] <= cx_reg[l] + dx;
                    cy_reg[l] <= cy_reg[l] - dy;
                    cz_reg[l] <= cz_reg[l] + $signed({1'b0, atan_v});
                end
            end
        end
    end

    // Shared multiplier for the three-way products.
    logic [2:0]  term;
    logic [1:0]  phase;
    logic [1:0]  comp;
    logic [2:0]  sel;
    logic signed [31:0] op_r, op_p, op_y, mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic signed [31:0] tmp_reg;
    logic signed [33:0] first_reg;
    logic signed [33:0] rnd_v;
    logic signed [64:0] rnd_sum;
    logic signed [34:0] acc;
    logic signed [31:0] sat_v;

    assign term  = cmd.iter[4:2];
    assign phase = cmd.iter[1:0];
    assign comp  = term[2:1];
    assign sel   = term_sel(term);
    assign op_r  = sel[2] ? sin_v[2] : cos_v[2];
    assign op_p  = sel[1] ? sin_v[0] : cos_v[0];
    assign op_y  = sel[0] ? sin_v[1] : cos_v[1];
    assign mul_a = (phase == 2'd0) ? op_r : tmp_reg;
    assign mul_b = (phase == 2'd0) ? op_p : op_y;

    // Round Q4.60 to Q2.30, halves up.
    assign rnd_sum = 65'(prod_reg) + 65'sd536870912;
    assign rnd_v   = 34'(rnd_sum >>> 30);
    // Components x and z subtract their second term.
    assign acc     = comp[0] ? (35'(first_reg) - 35'(rnd_v)) : (35'(first_reg) + 35'(rnd_v));

    always_comb
    begin
        if (acc > 35'(Q30_ONE))
        begin
            sat_v = 32'(Q30_ONE);
        end
        else if (acc < -35'(Q30_ONE))
        begin
            sat_v = -32'(Q30_ONE);
        end
        else
        begin
            sat_v = 32'(acc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod_step)
        begin
            case (phase)
                2'd0, 2'd2: prod_reg <= mul_a * mul_b;
                2'd1:       tmp_reg  <= 32'(rnd_v);
                default:
                begin
                    if (!term[0])
                    begin
                        first_reg <= rnd_v;
                    end
                end
            endcase
        end
    end

    // Held pose and quaternion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_t_reg[i] <= '0;
                held_a_reg[i] <= '0;
            end
            held_q_reg[0] <= 32'(Q30_ONE);
            held_q_reg[1] <= '0;
            held_q_reg[2] <= '0;
            held_q_reg[3] <= '0;
        end
        else
        begin
            if (cmd.load && st.changed)
            begin
                held_t_reg[0] <= in_tx;
                held_t_reg[1] <= in_ty;
                held_t_reg[2] <= in_tz;
                for (int i = 0; i < 3; i++)
                begin
                    held_a_reg[i] <= in_ang[i];
                end
            end
            if (cmd.prod_step && (phase == 2'd3) && term[0])
            begin
                held_q_reg[comp] <= sat_v;
            end
        end
    end

    // Latched pass-through fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sec_reg     <= in_sec;
            ns_reg      <= in_ns;
            tx_reg      <= in_tx;
            ty_reg      <= in_ty;
            tz_reg      <= in_tz;
            changed_reg <= st.changed;
        end
    end

    // Output register.
    logic [31:0] neg_y;
    logic [OUT_W-1:0] m_data_reg;
    assign neg_y = (ty_reg == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - ty_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_data_reg <= {1'b0, changed_reg, held_q_reg[3], held_q_reg[2], held_q_reg[1],
                           held_q_reg[0], tz_reg, neg_y, tx_reg, ns_reg, sec_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire
